>>> sv/wbcm_pkg.sv
// Shared types and constants for the word bag concatenation matcher.
// Used by the cell modules, the top level and the bench; depends on nothing.
package wbcm_pkg;

    localparam int WORDS_MAX_DFLT    = 8;
    localparam int WORD_LEN_MAX_DFLT = 8;
    localparam int BYTE_W            = 8;
    localparam int CFG_W             = 4;
    localparam int CFG_INDEX_W       = 1;
    localparam int POS_W             = 32;

    localparam logic [CFG_W-1:0] WORD_LEN_RESET   = 4'd3;
    localparam logic [CFG_W-1:0] WORD_COUNT_RESET = 4'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_WORD_LEN   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEXT  = 2'd1,
        OP_NEW   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] ch;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] start_index;
    } result_t;

    typedef struct packed {
        logic clear;
        logic step;
    } claim_ctl_t;

endpackage

>>> sv/wbcm_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is set per instance; no package dependency.
interface wbcm_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

>>> sv/wbcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module wbcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/wbcm_lane_cell.sv
// One cell of a character chain: a byte shift line tapped at the current word length.
// Hands its oldest byte to the next cell; uses wbcm_pkg constants.
module wbcm_lane_cell #(
    parameter int WORD_LEN_MAX = wbcm_pkg::WORD_LEN_MAX_DFLT,
    localparam int LW          = (WORD_LEN_MAX > 1) ? $clog2(WORD_LEN_MAX) : 1
) (
    input  logic                                     clk,
    input  logic                                     shift,
    input  logic [wbcm_pkg::BYTE_W-1:0]              din,
    input  logic [LW-1:0]                            tap_sel,
    output logic [wbcm_pkg::BYTE_W-1:0]              dout,
    output logic [WORD_LEN_MAX-1:0][wbcm_pkg::BYTE_W-1:0] bytes
);

    logic [WORD_LEN_MAX-1:0][wbcm_pkg::BYTE_W-1:0] bytes_reg;
    logic [WORD_LEN_MAX-1:0][wbcm_pkg::BYTE_W-1:0] bytes_next;

    always_comb
    begin
        bytes_next = bytes_reg;
        if (shift)
        begin
            bytes_next[0] = din;
            for (int j = 1; j < WORD_LEN_MAX; j++)
            begin
                bytes_next[j] = bytes_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign dout  = bytes_reg[tap_sel];
    assign bytes = bytes_reg;

endmodule

>>> sv/wbcm_claim_cell.sv
// One chunk slot of the claim chain: compares its chunk with the word on
// the broadcast bus and takes the passing token once. Uses wbcm_pkg.
module wbcm_claim_cell #(
    parameter int WORD_LEN_MAX = wbcm_pkg::WORD_LEN_MAX_DFLT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  wbcm_pkg::claim_ctl_t                          ctl,
    input  logic                                          active,
    input  logic [WORD_LEN_MAX-1:0]                       mask,
    input  logic [WORD_LEN_MAX-1:0][wbcm_pkg::BYTE_W-1:0] chunk,
    input  logic [WORD_LEN_MAX-1:0][wbcm_pkg::BYTE_W-1:0] word,
    input  logic                                          token_in,
    output logic                                          token_out
);

    logic                    used_reg;
    logic                    used_next;
    logic [WORD_LEN_MAX-1:0] byte_ok;
    logic                    hit;

    always_comb
    begin
        for (int j = 0; j < WORD_LEN_MAX; j++)
        begin
            byte_ok[j] = (chunk[j] == word[j]) || !mask[j];
        end
    end

    assign hit       = token_in && active && !used_reg && (&byte_ok);
    assign token_out = token_in && !hit;

    always_comb
    begin
        used_next = used_reg;
        if (ctl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctl.step && hit)
        begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

>>> sv/word_bag_concatenation_match_core.sv
// Word bag concatenation matcher, top level; needs wbcm_pkg, wbcm_stream_if, wbcm_ram, cells.
// Load, new-text, clear and text ops that start no window check: one transfer per cycle.
// A text character that fills a window holds item.ready low while the words are checked, one
// word per cycle and stopping on a miss, and while the result slot is full; the result is
// registered once the last word is claimed. A register write keeps item.ready low (refill).
// Reset: registers 3 and 2, word list empty, position and fill zero.
module word_bag_concatenation_match_core #(
    parameter int WORDS_MAX    = wbcm_pkg::WORDS_MAX_DFLT,
    parameter int WORD_LEN_MAX = wbcm_pkg::WORD_LEN_MAX_DFLT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    wbcm_stream_if.sink                        item,
    wbcm_stream_if.source                      result,
    input  logic                               cfg_wen,
    input  logic [wbcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wbcm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int WIN_LEN = WORDS_MAX * WORD_LEN_MAX;
    localparam int CW      = $clog2(WIN_LEN + 1);
    localparam int AW      = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int DEPTH   = 2 ** AW;
    localparam int SW      = $clog2(WORD_LEN_MAX + 1);
    localparam int KW      = $clog2(WORDS_MAX + 1);
    localparam int MW      = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
    localparam int LW      = (WORD_LEN_MAX > 1) ? $clog2(WORD_LEN_MAX) : 1;
    localparam int CMPW    = 6;
    localparam int BW      = wbcm_pkg::BYTE_W;
    localparam int PW      = wbcm_pkg::POS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_HOLD,
        ST_REBUILD
    } state_t;

    typedef logic [WORD_LEN_MAX-1:0][BW-1:0] lane_t;

    state_t                     state_reg, state_next;
    logic [MW-1:0]              m_reg, m_next;
    logic [CW-1:0]              i_reg, i_next;
    logic                       pend_reg, pend_next;
    logic                       text_fv_reg, text_fv_next;
    logic                       word_fv_reg, word_fv_next;
    logic [CW-1:0]              lp_reg, lp_next;
    logic [AW-1:0]              wptr_reg, wptr_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [PW-1:0]              start_reg, start_next;
    logic [wbcm_pkg::CFG_W-1:0] wlen_reg, wlen_next;
    logic [wbcm_pkg::CFG_W-1:0] word_count_reg, word_count_next;
    logic                       out_valid_reg, out_valid_next;
    wbcm_pkg::result_t          out_data_reg, out_data_next;

    logic [SW-1:0]              ws_eff;
    logic [KW-1:0]              wc_eff;
    logic [CW-1:0]              total;
    logic [CW-1:0]              fill_inc;
    logic [LW-1:0]              tap_sel;
    logic [WORD_LEN_MAX-1:0]    lane_mask;
    logic                       accept;
    logic                       slot_free;
    logic                       push;
    logic                       last_word;
    logic                       not_found;
    wbcm_pkg::claim_ctl_t       ctl;

    logic                       text_we, word_we;
    logic                       text_shift, word_shift;
    logic [BW-1:0]              text_din, word_din;
    logic [BW-1:0]              text_rdata, word_rdata;
    logic [AW-1:0]              text_raddr;

    logic [BW-1:0]              text_link [WORDS_MAX+1];
    logic [BW-1:0]              word_link [WORDS_MAX+1];
    lane_t                      chunk_bytes [WORDS_MAX];
    lane_t                      word_bytes [WORDS_MAX];
    lane_t                      word_bus;
    logic                       token [WORDS_MAX+1];

    // Clamp the registers to the supported range
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            ws_eff = SW'(1);
        end
        else if (CMPW'(wlen_reg) > CMPW'(WORD_LEN_MAX))
        begin
            ws_eff = SW'(WORD_LEN_MAX);
        end
        else
        begin
            ws_eff = SW'(wlen_reg);
        end

        if (word_count_reg == '0)
        begin
            wc_eff = KW'(1);
        end
        else if (CMPW'(word_count_reg) > CMPW'(WORDS_MAX))
        begin
            wc_eff = KW'(WORDS_MAX);
        end
        else
        begin
            wc_eff = KW'(word_count_reg);
        end
    end

    assign total    = CW'(ws_eff) * CW'(wc_eff);
    assign tap_sel  = LW'(ws_eff - SW'(1));
    assign fill_inc = (fill_reg < CW'(WIN_LEN)) ? fill_reg + CW'(1) : fill_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_LEN_MAX; j++)
        begin
            lane_mask[j] = SW'(j) < ws_eff;
        end
    end

    assign item.ready = (state_reg == ST_IDLE) && !pend_reg;
    assign accept     = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign last_word  = KW'(m_reg) == (wc_eff - KW'(1));
    assign text_raddr = wptr_reg - AW'(total) + AW'(i_reg);
    assign word_bus   = word_bytes[m_reg];
    assign not_found  = token[WORDS_MAX];

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    wbcm_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (wptr_reg),
        .wdata (item.payload.ch),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    wbcm_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (lp_reg[AW-1:0]),
        .wdata (item.payload.ch),
        .raddr (i_reg[AW-1:0]),
        .rdata (word_rdata)
    );

    assign text_link[0] = text_din;
    assign word_link[0] = word_din;
    assign token[0]     = 1'b1;

    for (genvar k = 0; k < WORDS_MAX; k++)
    begin : g_cell
        logic active;

        assign active = KW'(k) < wc_eff;

        wbcm_lane_cell #(
            .WORD_LEN_MAX (WORD_LEN_MAX)
        ) u_text_cell (
            .clk     (clk),
            .shift   (text_shift),
            .din     (text_link[k]),
            .tap_sel (tap_sel),
            .dout    (text_link[k+1]),
            .bytes   (chunk_bytes[k])
        );

        wbcm_lane_cell #(
            .WORD_LEN_MAX (WORD_LEN_MAX)
        ) u_word_cell (
            .clk     (clk),
            .shift   (word_shift),
            .din     (word_link[k]),
            .tap_sel (tap_sel),
            .dout    (word_link[k+1]),
            .bytes   (word_bytes[k])
        );

        wbcm_claim_cell #(
            .WORD_LEN_MAX (WORD_LEN_MAX)
        ) u_claim_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .active    (active),
            .mask      (lane_mask),
            .chunk     (chunk_bytes[k]),
            .word      (word_bus),
            .token_in  (token[k]),
            .token_out (token[k+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        pend_next       = pend_reg;
        text_fv_next    = 1'b0;
        word_fv_next    = 1'b0;
        lp_next         = lp_reg;
        wptr_next       = wptr_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        start_next      = start_reg;
        wlen_next       = wlen_reg;
        word_count_next = word_count_reg;
        ctl.clear       = 1'b0;
        ctl.step        = 1'b0;
        push            = 1'b0;
        text_we         = 1'b0;
        word_we         = 1'b0;
        text_shift      = text_fv_reg;
        word_shift      = word_fv_reg;
        text_din        = text_rdata;
        word_din        = word_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    state_next = ST_REBUILD;
                    i_next     = '0;
                    pend_next  = 1'b0;
                end
                else if (accept)
                begin
                    unique case (wbcm_pkg::op_t'(item.payload.op))
                        wbcm_pkg::OP_LOAD:
                        begin
                            if (lp_reg < total)
                            begin
                                word_we    = 1'b1;
                                word_shift = 1'b1;
                                word_din   = item.payload.ch;
                                lp_next    = lp_reg + CW'(1);
                            end
                        end
                        wbcm_pkg::OP_TEXT:
                        begin
                            text_we    = 1'b1;
                            text_shift = 1'b1;
                            text_din   = item.payload.ch;
                            wptr_next  = wptr_reg + AW'(1);
                            pos_next   = pos_reg + PW'(1);
                            fill_next  = fill_inc;
                            start_next = pos_reg + PW'(1) - PW'(total);
                            if (lp_reg >= total && fill_inc >= total)
                            begin
                                state_next = ST_MATCH;
                                m_next     = '0;
                                ctl.clear  = 1'b1;
                            end
                        end
                        wbcm_pkg::OP_NEW:
                        begin
                            pos_next  = '0;
                            fill_next = '0;
                        end
                        wbcm_pkg::OP_CLEAR:
                        begin
                            lp_next = '0;
                        end
                    endcase
                end
            end
            ST_MATCH:
            begin
                ctl.step = 1'b1;
                if (not_found)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_word)
                begin
                    if (slot_free)
                    begin
                        push       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    m_next = m_reg + MW'(1);
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REBUILD:
            begin
                // Replay the stored characters through both chains, oldest first
                if (i_reg < total)
                begin
                    text_fv_next = 1'b1;
                    word_fv_next = i_reg < lp_reg;
                    i_next       = i_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (cfg_wen)
        begin
            unique case (cfg_index)
                wbcm_pkg::REG_WORD_LEN:   wlen_next       = cfg_data;
                wbcm_pkg::REG_WORD_COUNT: word_count_next = cfg_data;
            endcase
            pend_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next            = 1'b1;
            out_data_next.start_index = start_reg;
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_reg          <= '0;
            i_reg          <= '0;
            pend_reg       <= 1'b0;
            text_fv_reg    <= 1'b0;
            word_fv_reg    <= 1'b0;
            lp_reg         <= '0;
            wptr_reg       <= '0;
            pos_reg        <= '0;
            fill_reg       <= '0;
            start_reg      <= '0;
            wlen_reg       <= wbcm_pkg::WORD_LEN_RESET;
            word_count_reg <= wbcm_pkg::WORD_COUNT_RESET;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            pend_reg       <= pend_next;
            text_fv_reg    <= text_fv_next;
            word_fv_reg    <= word_fv_next;
            lp_reg         <= lp_next;
            wptr_reg       <= wptr_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            start_reg      <= start_next;
            wlen_reg       <= wlen_next;
            word_count_reg <= word_count_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

>>> bench/word_bag_concatenation_match_core_test.sv
// Self-checking bench for word_bag_concatenation_match_core: streams word-list loads and
// text characters with random bursts and receiver stalls, predicts each match start.
// Depends on wbcm_pkg, wbcm_stream_if and the core itself.
module word_bag_concatenation_match_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WMAX           = wbcm_pkg::WORDS_MAX_DFLT;
    localparam int LMAX           = wbcm_pkg::WORD_LEN_MAX_DFLT;
    localparam int WIN            = WMAX * LMAX;
    localparam int IDLE_GAP       = WMAX + 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum {LIST_RELOAD, LIST_KEEP, LIST_PARTIAL} list_plan_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wen;
    logic [wbcm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wbcm_pkg::CFG_W-1:0]       cfg_data;

    wbcm_stream_if #(.payload_t(wbcm_pkg::item_t))   item_if ();
    wbcm_stream_if #(.payload_t(wbcm_pkg::result_t)) result_if ();

    word_bag_concatenation_match_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wbcm_pkg::item_t   pending_items [$];
    wbcm_pkg::result_t expected_starts [$];

    logic [wbcm_pkg::CFG_W-1:0] mdl_ws;
    logic [wbcm_pkg::CFG_W-1:0] mdl_wc;
    logic [7:0]       mdl_store [WIN];
    logic [7:0]       mdl_window [WIN];
    int               mdl_loaded;
    int               mdl_fill;
    logic [31:0]      mdl_pos;

    logic [7:0] stim_store [WIN];
    int         stim_loaded;
    int         stim_total;

    int  items_queued;
    int  items_accepted;
    int  results_seen;
    int  mismatches;
    int  settings_seen;
    int  cycle_count;
    int  burst_left;
    int  gap_left;
    int  rx_cycle;
    logic [31:0] rx_mask;
    logic rx_holdoff;
    bit   holdoff_go;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int clamp_field(logic [wbcm_pkg::CFG_W-1:0] v, int hi);
        if (v == '0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic bit window_is_word_bag(int ws, int wc);
        bit taken [WMAX];
        int base_idx;
        bit found;
        bit same;
        base_idx = WIN - ws * wc;
        for (int w = 0; w < WMAX; w++)
            taken[w] = 1'b0;
        for (int c = 0; c < wc; c++)
        begin
            found = 1'b0;
            for (int w = 0; w < wc; w++)
            begin
                if (!taken[w] && !found)
                begin
                    same = 1'b1;
                    for (int j = 0; j < ws; j++)
                        if (mdl_window[base_idx + c * ws + j] != mdl_store[w * ws + j])
                            same = 1'b0;
                    if (same)
                    begin
                        taken[w] = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_matcher(wbcm_pkg::item_t it);
        int ws;
        int wc;
        int total;
        wbcm_pkg::result_t hit;
        ws = clamp_field(mdl_ws, LMAX);
        wc = clamp_field(mdl_wc, WMAX);
        total = ws * wc;
        case (wbcm_pkg::op_t'(it.op))
            wbcm_pkg::OP_LOAD:
            begin
                if (mdl_loaded < total)
                begin
                    mdl_store[mdl_loaded] = it.ch;
                    mdl_loaded++;
                end
            end
            wbcm_pkg::OP_NEW:
            begin
                for (int i = 0; i < WIN; i++)
                    mdl_window[i] = 8'h00;
                mdl_pos = '0;
                mdl_fill = 0;
            end
            wbcm_pkg::OP_CLEAR:
                mdl_loaded = 0;
            default:
            begin
                for (int i = 0; i < WIN - 1; i++)
                    mdl_window[i] = mdl_window[i + 1];
                mdl_window[WIN - 1] = it.ch;
                if (mdl_fill < WIN)
                    mdl_fill++;
                hit.start_index = mdl_pos + 32'd1 - 32'(total);
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_loaded >= total && mdl_fill >= total && window_is_word_bag(ws, wc))
                    expected_starts.insert(expected_starts.size(), hit);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic push_item(wbcm_pkg::op_t op, logic [7:0] ch);
        wbcm_pkg::item_t it;
        it.op = op;
        it.ch = ch;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
        if (op == wbcm_pkg::OP_LOAD && stim_loaded < stim_total)
        begin
            stim_store[stim_loaded] = ch;
            stim_loaded++;
        end
        else if (op == wbcm_pkg::OP_CLEAR)
            stim_loaded = 0;
    endtask

    task automatic drain_to_idle();
        while (pending_items.size() != 0 || item_if.valid || expected_starts.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_register(logic [wbcm_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [wbcm_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == wbcm_pkg::REG_WORD_LEN)
            mdl_ws = val;
        else
            mdl_wc = val;
    endtask

    task automatic run_phase(logic [wbcm_pkg::CFG_W-1:0] ws_val,
                             logic [wbcm_pkg::CFG_W-1:0] wc_val,
                             list_plan_t plan, int n_items, bit squeeze);
        int ws;
        int wc;
        int target;
        int pick;
        int n_loads;
        int j;
        int tmp;
        int order [WMAX];
        logic [7:0] alpha [3];
        drain_to_idle();
        write_register(wbcm_pkg::REG_WORD_LEN, ws_val);
        write_register(wbcm_pkg::REG_WORD_COUNT, wc_val);
        ws = clamp_field(ws_val, LMAX);
        wc = clamp_field(wc_val, WMAX);
        stim_total = ws * wc;
        settings_seen++;
        for (int a = 0; a < 3; a++)
            alpha[a] = 8'($urandom_range(0, 255));
        if (plan != LIST_KEEP)
        begin
            push_item(wbcm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
            n_loads = (plan == LIST_RELOAD) ? stim_total + $urandom_range(0, 2)
                                            : $urandom_range(0, stim_total - 1);
            for (int k = 0; k < n_loads; k++)
                push_item(wbcm_pkg::OP_LOAD, alpha[$urandom_range(0, 1)]);
        end
        if (squeeze)
            holdoff_go = 1'b1;
        push_item(wbcm_pkg::OP_NEW, 8'($urandom_range(0, 255)));
        target = items_queued + n_items;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && stim_loaded >= stim_total)
            begin
                for (int k = 0; k < wc; k++)
                    order[k] = k;
                for (int k = wc - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (int k = 0; k < wc; k++)
                    for (int c = 0; c < ws; c++)
                        push_item(wbcm_pkg::OP_TEXT, stim_store[order[k] * ws + c]);
            end
            else if (pick < 80)
                push_item(wbcm_pkg::OP_TEXT, alpha[$urandom_range(0, 2)]);
            else if (pick < 88)
                push_item(wbcm_pkg::OP_TEXT, 8'($urandom_range(0, 255)));
            else if (pick < 91)
                push_item(wbcm_pkg::OP_NEW, 8'($urandom_range(0, 255)));
            else if (pick < 94)
                push_item(wbcm_pkg::OP_LOAD, alpha[$urandom_range(0, 1)]);
            else if (pick < 96)
            begin
                push_item(wbcm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                for (int k = 0; k < stim_total; k++)
                    push_item(wbcm_pkg::OP_LOAD, alpha[$urandom_range(0, 1)]);
            end
            else
                push_item(wbcm_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // driver: advance through pending items in bursts, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid   <= 1'b0;
            item_if.payload <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
            begin
                advance_matcher(item_if.payload);
                items_accepted++;
            end
            if (!item_if.valid || item_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_if.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item_if.payload <= pending_items.pop_front();
                    item_if.valid   <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    item_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            rx_cycle = 0;
            rx_mask  = '1;
        end
        else
        begin
            if (rx_cycle % 64 == 0)
                rx_mask = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | $urandom);
            result_if.ready <= rx_mask[rx_cycle % 32] && !rx_holdoff;
            rx_cycle++;
        end
    end

    // hold the receiver off for a long stretch once asked
    initial
    begin
        rx_holdoff = 1'b0;
        wait (holdoff_go);
        @(posedge clk);
        rx_holdoff <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_holdoff <= 1'b0;
    end

    always @(posedge clk)
    begin : check_result
        wbcm_pkg::result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (expected_starts.size() == 0)
                report_mismatch($sformatf("start_index %0d with no match pending",
                                          result_if.payload.start_index));
            else
            begin
                want = expected_starts.pop_front();
                if (result_if.payload.start_index !== want.start_index)
                    report_mismatch($sformatf("start_index %0d, predicted %0d",
                                              result_if.payload.start_index,
                                              want.start_index));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("word_bag_concatenation_match_core test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        result_if.ready = 1'b0;
        cycle_count     = 0;
        holdoff_go      = 1'b0;
        mdl_ws          = wbcm_pkg::WORD_LEN_RESET;
        mdl_wc          = wbcm_pkg::WORD_COUNT_RESET;
        mdl_loaded      = 0;
        mdl_fill        = 0;
        mdl_pos         = '0;
        stim_loaded     = 0;
        stim_total      = int'(wbcm_pkg::WORD_LEN_RESET) * int'(wbcm_pkg::WORD_COUNT_RESET);
        items_queued    = 0;
        items_accepted  = 0;
        results_seen    = 0;
        mismatches      = 0;
        settings_seen   = 1;
        for (int i = 0; i < WIN; i++)
        begin
            mdl_store[i]  = 8'h00;
            mdl_window[i] = 8'h00;
            stim_store[i] = 8'h00;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text before the list is complete, full list, ignored extra load, one match
        push_item(wbcm_pkg::OP_TEXT, 8'h41);
        push_item(wbcm_pkg::OP_TEXT, 8'h42);
        push_item(wbcm_pkg::OP_LOAD, 8'h00);
        push_item(wbcm_pkg::OP_LOAD, 8'hFF);
        push_item(wbcm_pkg::OP_LOAD, 8'h5A);
        push_item(wbcm_pkg::OP_LOAD, 8'hA5);
        push_item(wbcm_pkg::OP_LOAD, 8'h00);
        push_item(wbcm_pkg::OP_LOAD, 8'hFF);
        push_item(wbcm_pkg::OP_LOAD, 8'h77);
        push_item(wbcm_pkg::OP_NEW, 8'hFF);
        push_item(wbcm_pkg::OP_TEXT, 8'hA5);
        push_item(wbcm_pkg::OP_TEXT, 8'h00);
        push_item(wbcm_pkg::OP_TEXT, 8'hFF);
        push_item(wbcm_pkg::OP_TEXT, 8'h00);
        push_item(wbcm_pkg::OP_TEXT, 8'hFF);
        push_item(wbcm_pkg::OP_TEXT, 8'h5A);
        push_item(wbcm_pkg::OP_TEXT, 8'h00);
        push_item(wbcm_pkg::OP_CLEAR, 8'h00);
        push_item(wbcm_pkg::OP_TEXT, 8'h00);
        push_item(wbcm_pkg::OP_TEXT, 8'hFF);

        run_phase(4'd0, 4'd0, LIST_RELOAD, 40, 1'b0);
        run_phase(4'd1, 4'd1, LIST_RELOAD, 55, 1'b1);
        run_phase(4'd8, 4'd8, LIST_RELOAD, 80, 1'b0);
        run_phase(4'd15, 4'd15, LIST_KEEP, 30, 1'b0);
        run_phase(4'd2, 4'd3, LIST_KEEP, 40, 1'b0);
        run_phase(4'd9, 4'd1, LIST_RELOAD, 50, 1'b0);
        run_phase(4'd1, 4'd9, LIST_RELOAD, 50, 1'b0);
        run_phase(4'd4, 4'd2, LIST_PARTIAL, 30, 1'b0);
        for (int p = 0; p < 4; p++)
            run_phase(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                      LIST_RELOAD, 40, 1'b0);
        run_phase(4'd3, 4'd2, LIST_KEEP, 40, 1'b0);

        drain_to_idle();
        if (expected_starts.size() != 0)
            report_mismatch($sformatf("%0d predicted starts never arrived",
                                      expected_starts.size()));
        $display("Covered %0d item transfers and %0d match starts over %0d register settings,",
                 items_accepted, results_seen, settings_seen);
        $display("including clamped sizes, reread word lists and a long receiver hold-off.");
        if (mismatches == 0)
            $display("word_bag_concatenation_match_core test passed");
        else
            $display("word_bag_concatenation_match_core test failed");
        $finish;
    end

endmodule
